[design/rvx_pkg.sv]
package rvx_pkg;

	localparam int unsigned MemBytes = 4096;
	localparam int unsigned NumBanks = 4;
	localparam int unsigned MemRows = MemBytes / NumBanks;
	localparam int unsigned RowW = $clog2(MemRows);
	localparam int unsigned NumRegs = 32;

	localparam logic [31:0] StartPcReset = 32'h0000_0000;
	localparam logic CfgStartPc = 1'b0;

	typedef enum logic [5:0] {
		OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRL, OP_SRA,
		OP_SLT, OP_SLTU, OP_ADDI, OP_ANDI, OP_ORI, OP_XORI, OP_SLLI, OP_SRLI,
		OP_SRAI, OP_SLTI, OP_SLTIU, OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW,
		OP_SB, OP_SH, OP_SW, OP_BEQ, OP_BGE, OP_BGEU, OP_BLT, OP_BLTU,
		OP_BNE, OP_JAL, OP_JALR, OP_AUIPC, OP_LUI, OP_MUL
	} op_t;

	typedef enum logic [2:0] {
		LD_NONE, LD_B, LD_BU, LD_H, LD_HU, LD_W
	} ld_t;

	typedef enum logic [1:0] {
		ST_NONE, ST_B, ST_H, ST_W
	} st_t;

	typedef struct packed {
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        taken;
		logic [31:0] npc;
		logic [31:0] addr;
		ld_t         ld;
		st_t         st;
	} exec_t;

endpackage

[design/rvx_alu.sv]
module rvx_alu (
	input  logic [5:0]         op,
	input  logic [4:0]         rd,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  logic signed [20:0] imm,
	input  logic [31:0]        pc,
	output rvx_pkg::exec_t     res
);

	logic [31:0] immx;
	logic [31:0] i12;
	logic [31:0] upper;
	logic [31:0] pc4;
	logic [31:0] addr;
	logic [31:0] prod;
	logic [4:0]  shr;
	logic [4:0]  shi;
	logic [31:0] val;
	logic [31:0] npc;
	logic        wr;
	logic        taken;
	logic        cond;
	logic        is_branch;
	rvx_pkg::ld_t ld;
	rvx_pkg::st_t st;

	assign immx  = {{11{imm[20]}}, imm};
	assign i12   = {{20{imm[11]}}, imm[11:0]};
	assign upper = {imm[19:0], 12'h000};
	assign pc4   = pc + 32'd4;
	assign addr  = a + i12;
	assign prod  = a * b;
	assign shr   = b[4:0];
	assign shi   = imm[4:0];

	always_comb begin
		val       = '0;
		wr        = 1'b0;
		cond      = 1'b0;
		is_branch = 1'b0;
		taken     = 1'b0;
		npc       = pc4;
		ld        = rvx_pkg::LD_NONE;
		st        = rvx_pkg::ST_NONE;
		unique case (rvx_pkg::op_t'(op))
			rvx_pkg::OP_ADD: begin val = a + b; wr = 1'b1; end
			rvx_pkg::OP_SUB: begin val = a - b; wr = 1'b1; end
			rvx_pkg::OP_AND: begin val = a & b; wr = 1'b1; end
			rvx_pkg::OP_OR: begin val = a | b; wr = 1'b1; end
			rvx_pkg::OP_XOR: begin val = a ^ b; wr = 1'b1; end
			rvx_pkg::OP_SLL: begin val = a << shr; wr = 1'b1; end
			rvx_pkg::OP_SRL: begin val = a >> shr; wr = 1'b1; end
			rvx_pkg::OP_SRA: begin val = 32'($signed(a) >>> shr); wr = 1'b1; end
			rvx_pkg::OP_SLT: begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
			rvx_pkg::OP_SLTU: begin val = {31'd0, a < b}; wr = 1'b1; end
			rvx_pkg::OP_ADDI: begin val = addr; wr = 1'b1; end
			rvx_pkg::OP_ANDI: begin val = a & i12; wr = 1'b1; end
			rvx_pkg::OP_ORI: begin val = a | i12; wr = 1'b1; end
			rvx_pkg::OP_XORI: begin val = a ^ i12; wr = 1'b1; end
			rvx_pkg::OP_SLLI: begin val = a << shi; wr = 1'b1; end
			rvx_pkg::OP_SRLI: begin val = a >> shi; wr = 1'b1; end
			rvx_pkg::OP_SRAI: begin val = 32'($signed(a) >>> shi); wr = 1'b1; end
			rvx_pkg::OP_SLTI: begin val = {31'd0, $signed(a) < $signed(i12)}; wr = 1'b1; end
			rvx_pkg::OP_SLTIU: begin val = {31'd0, a < i12}; wr = 1'b1; end
			rvx_pkg::OP_LB: begin ld = rvx_pkg::LD_B; wr = 1'b1; end
			rvx_pkg::OP_LBU: begin ld = rvx_pkg::LD_BU; wr = 1'b1; end
			rvx_pkg::OP_LH: begin ld = rvx_pkg::LD_H; wr = 1'b1; end
			rvx_pkg::OP_LHU: begin ld = rvx_pkg::LD_HU; wr = 1'b1; end
			rvx_pkg::OP_LW: begin ld = rvx_pkg::LD_W; wr = 1'b1; end
			rvx_pkg::OP_SB: st = rvx_pkg::ST_B;
			rvx_pkg::OP_SH: st = rvx_pkg::ST_H;
			rvx_pkg::OP_SW: st = rvx_pkg::ST_W;
			rvx_pkg::OP_BEQ: begin is_branch = 1'b1; cond = (a == b); end
			rvx_pkg::OP_BGE: begin is_branch = 1'b1; cond = !($signed(a) < $signed(b)); end
			rvx_pkg::OP_BGEU: begin is_branch = 1'b1; cond = (a >= b); end
			rvx_pkg::OP_BLT: begin is_branch = 1'b1; cond = ($signed(a) < $signed(b)); end
			rvx_pkg::OP_BLTU: begin is_branch = 1'b1; cond = (a < b); end
			rvx_pkg::OP_BNE: begin is_branch = 1'b1; cond = (a != b); end
			rvx_pkg::OP_JAL: begin
				val   = pc4;
				wr    = 1'b1;
				taken = 1'b1;
				npc   = pc + immx;
			end
			rvx_pkg::OP_JALR: begin
				val   = pc4;
				wr    = 1'b1;
				taken = 1'b1;
				npc   = {addr[31:1], 1'b0};
			end
			rvx_pkg::OP_AUIPC: begin val = pc + upper; wr = 1'b1; end
			rvx_pkg::OP_LUI: begin val = upper; wr = 1'b1; end
			rvx_pkg::OP_MUL: begin val = prod; wr = 1'b1; end
			default: ;
		endcase
		if (is_branch && cond) begin
			taken = 1'b1;
			npc   = pc + immx;
		end
	end

	always_comb begin
		res.wr    = wr && (rd != 5'd0);
		res.rd    = res.wr ? rd : 5'd0;
		res.val   = res.wr ? val : 32'd0;
		res.taken = taken;
		res.npc   = npc;
		res.addr  = addr;
		res.ld    = ld;
		res.st    = st;
	end

endmodule

[design/rv32i_execute_with_mul_unit.sv]
// RV32I execute unit with a combinational multiplier in stage 1.
// Input channel (in_valid, in_stall): one decoded instruction per transaction
// with operation, rd, rs1, rs2 and a signed 21-bit immediate.
// Output channel (out_valid, out_stall): one result per instruction with the
// register write (reg_written, write_index, write_value), branch_taken and next_pc.
// An accepted instruction passes the stage 1 registers, then the stage 2 result
// register that drives the outputs. Throughput is one instruction per cycle
// while out_stall is low; operands are forwarded from the result stage into
// the multiplier. Loads, stores and dependent instructions run back to back.
// The data memory is four byte-wide banks; a load reads all four banks and a
// store writes the bytes it covers, so unaligned accesses do not stall.
// After reset the data memory is cleared one row of four bytes per cycle, all
// MemBytes/4 rows (1024 at the default size), with in_stall held high.
// Configuration writes through the APB port are taken during that time.
// When out_stall holds a result, the result stays in place; one more
// instruction can still enter the first stage, after which in_stall rises.
module rv32i_execute_with_mul_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [5:0]         operation,
	input  logic [4:0]         rd,
	input  logic [4:0]         rs1,
	input  logic [4:0]         rs2,
	input  logic signed [20:0] imm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               reg_written,
	output logic [4:0]         write_index,
	output logic [31:0]        write_value,
	output logic               branch_taken,
	output logic [31:0]        next_pc,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned RowW = rvx_pkg::RowW;
	localparam int unsigned NumBanks = rvx_pkg::NumBanks;

	logic [31:0] start_pc_q;
	logic [31:0] pc_q;
	logic        clearing_q;
	logic [RowW-1:0] clr_row_q;

	logic [31:0] rf_mem [rvx_pkg::NumRegs];
	logic [rvx_pkg::NumRegs-1:0] rf_valid_q;

	logic               valid_s1;
	logic [5:0]         op_s1;
	logic [4:0]         rd_s1;
	logic [4:0]         rs1_s1;
	logic [4:0]         rs2_s1;
	logic signed [20:0] imm_s1;
	logic [31:0]        rs1_data_s1;
	logic [31:0]        rs2_data_s1;

	logic               valid_s2;
	logic               wr_s2;
	logic [4:0]         rd_s2;
	logic [31:0]        val_s2;
	logic               taken_s2;
	logic [31:0]        npc_s2;
	rvx_pkg::ld_t       ld_s2;
	logic [1:0]         off_s2;

	logic in_accept;
	logic s1_adv;
	logic s2_adv;
	logic rf_we;
	logic [31:0] a_fwd;
	logic [31:0] b_fwd;
	logic [31:0] result_value;
	logic [31:0] load_value;
	rvx_pkg::exec_t exe;

	logic [7:0]      bank_dout_q [NumBanks];
	logic [7:0]      ld_byte [NumBanks];
	logic [1:0]      bank_idx [NumBanks];
	logic [RowW-1:0] bank_row [NumBanks];
	logic [7:0]      bank_wdata [NumBanks];
	logic            bank_we [NumBanks];
	logic            bank_re;

	// Pipeline flow control.
	assign s2_adv    = valid_s2 && !out_stall;
	assign s1_adv    = valid_s1 && (!valid_s2 || s2_adv);
	assign in_stall  = clearing_q || (valid_s1 && !s1_adv);
	assign in_accept = in_valid && !in_stall;
	assign rf_we     = s2_adv && wr_s2;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == rvx_pkg::CfgStartPc) ? start_pc_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= rvx_pkg::StartPcReset;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == rvx_pkg::CfgStartPc)) begin
			start_pc_q <= pwdata;
		end
	end

	// Memory clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + RowW'(1);
			if (clr_row_q == RowW'(rvx_pkg::MemRows - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Register file: written from the result stage, read on acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
		end else if (rf_we) begin
			rf_valid_q[rd_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rd_s2] <= result_value;
		end
		if (in_accept) begin
			if (rf_we && (rd_s2 == rs1)) begin
				rs1_data_s1 <= result_value;
			end else begin
				rs1_data_s1 <= rf_valid_q[rs1] ? rf_mem[rs1] : 32'd0;
			end
			if (rf_we && (rd_s2 == rs2)) begin
				rs2_data_s1 <= result_value;
			end else begin
				rs2_data_s1 <= rf_valid_q[rs2] ? rf_mem[rs2] : 32'd0;
			end
		end
	end

	// Stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1  <= operation;
			rd_s1  <= rd;
			rs1_s1 <= rs1;
			rs2_s1 <= rs2;
			imm_s1 <= imm;
		end
	end

	assign a_fwd = (valid_s2 && wr_s2 && (rd_s2 == rs1_s1)) ? result_value : rs1_data_s1;
	assign b_fwd = (valid_s2 && wr_s2 && (rd_s2 == rs2_s1)) ? result_value : rs2_data_s1;

	rvx_alu u_alu (
		.op  (op_s1),
		.rd  (rd_s1),
		.a   (a_fwd),
		.b   (b_fwd),
		.imm (imm_s1),
		.pc  (pc_q),
		.res (exe)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rvx_pkg::StartPcReset;
		end else if (s1_adv) begin
			pc_q <= exe.npc;
		end
	end

	// Data memory banks. Bank k holds the bytes whose address has k in its low bits.
	assign bank_re = s1_adv && (exe.ld != rvx_pkg::LD_NONE);

	for (genvar gk = 0; gk < NumBanks; gk++) begin : g_bank
		logic [7:0] dmem [rvx_pkg::MemRows];
		logic       st_hit;

		assign bank_idx[gk] = 2'(gk) - exe.addr[1:0];
		assign st_hit = (exe.st == rvx_pkg::ST_W)
			|| ((exe.st == rvx_pkg::ST_H) && (bank_idx[gk] < 2'd2))
			|| ((exe.st == rvx_pkg::ST_B) && (bank_idx[gk] == 2'd0));
		assign bank_we[gk] = clearing_q || (s1_adv && st_hit);
		assign bank_row[gk] = clearing_q ? clr_row_q
			: exe.addr[RowW+1:2] + RowW'(2'(gk) < exe.addr[1:0]);
		assign bank_wdata[gk] = clearing_q ? 8'h00
			: 8'(b_fwd >> {bank_idx[gk], 3'b000});

		always_ff @(posedge clk) begin
			if (bank_we[gk]) begin
				dmem[bank_row[gk]] <= bank_wdata[gk];
			end
			if (bank_re) begin
				bank_dout_q[gk] <= dmem[bank_row[gk]];
			end
		end

		assign ld_byte[gk] = bank_dout_q[off_s2 + 2'(gk)];
	end

	// Stage 2, the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			wr_s2    <= exe.wr;
			rd_s2    <= exe.rd;
			val_s2   <= exe.val;
			taken_s2 <= exe.taken;
			npc_s2   <= exe.npc;
			ld_s2    <= exe.ld;
			off_s2   <= exe.addr[1:0];
		end
	end

	always_comb begin
		unique case (ld_s2)
			rvx_pkg::LD_B:  load_value = {{24{ld_byte[0][7]}}, ld_byte[0]};
			rvx_pkg::LD_BU: load_value = {24'd0, ld_byte[0]};
			rvx_pkg::LD_H:  load_value = {{16{ld_byte[1][7]}}, ld_byte[1], ld_byte[0]};
			rvx_pkg::LD_HU: load_value = {16'd0, ld_byte[1], ld_byte[0]};
			rvx_pkg::LD_W:  load_value = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
			default:        load_value = 32'd0;
		endcase
	end

	assign result_value = (wr_s2 && (ld_s2 != rvx_pkg::LD_NONE)) ? load_value : val_s2;

	assign out_valid    = valid_s2;
	assign reg_written  = wr_s2;
	assign write_index  = rd_s2;
	assign write_value  = result_value;
	assign branch_taken = taken_s2;
	assign next_pc      = npc_s2;

endmodule

[design/rvx_checker.sv]
module rvx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        reg_written,
	input logic [4:0]  write_index,
	input logic [31:0] write_value,
	input logic        branch_taken,
	input logic [31:0] next_pc
);

	// Program counter left behind by the last delivered transaction.
	logic [31:0] last_npc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_npc_q <= 32'd0;
		end else if (out_valid && !out_stall) begin
			last_npc_q <= next_pc;
		end
	end

	a_no_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_written |-> (write_index == 5'd0) && (write_value == 32'd0))
		else $error("result without a register write carries a nonzero index or value");

	a_write_not_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> (write_index != 5'd0))
		else $error("register write reported for x0");

	a_sequential_pc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !branch_taken |-> (next_pc == last_npc_q + 32'd4))
		else $error("not-taken instruction did not advance the program counter by four");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(write_value))
		else $error("stalled result changed");

endmodule

bind rv32i_execute_with_mul_unit rvx_checker u_rvx_checker (.*);
